// ----- sv/cras_pkg.sv -----
// Shared constants, types and word functions of the contiguous run slot allocator.
`default_nettype none
package cras_pkg;

  localparam int WORD_W   = 32;
  localparam int OFS_W    = 5;
  localparam int OP_W     = 2;
  localparam int LEN_W    = 13;
  localparam int IDX_IN_W = 12;
  localparam int STAT_W   = 2;
  localparam int LIMIT_W  = 13;
  localparam int MARK_W   = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'hE00;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUST = 2'd2;

  typedef struct packed {
    logic             hit;
    logic             hit_lead;
    logic [OFS_W-1:0] int_start;
    logic             any_used;
    logic [OFS_W-1:0] last_used;
  } cras_eval_t;

  function automatic logic [WORD_W-1:0] span_mask(input logic [OFS_W-1:0] lo,
                                                  input logic [OFS_W:0]   hi);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      m[j] = ((OFS_W+1)'(j) >= {1'b0, lo}) && ((OFS_W+1)'(j) < hi);
    end
    return m;
  endfunction

  // bit j set when the c bits ending at j are all free
  function automatic logic [WORD_W-1:0] run_end_mask(input logic [WORD_W-1:0] f,
                                                     input logic [OFS_W:0]    c);
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] p;
    logic [OFS_W:0]    a;
    e = '1;
    p = f;
    a = '0;
    for (int k = 0; k <= OFS_W; k++) begin
      if (c[k]) begin
        e = e & (p << a);
        a = a + (OFS_W+1)'(1 << k);
      end
      p = p & (p << (1 << k));
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cras_if.sv -----
// Channel interfaces: operation input, result output and limit register write.
`default_nettype none
interface cras_op_if;
  import cras_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [LEN_W-1:0]    run_length;
  logic [IDX_IN_W-1:0] slot_index;
  modport source (output valid, opcode, run_length, slot_index, input ready);
  modport sink   (input valid, opcode, run_length, slot_index, output ready);
endinterface

interface cras_res_if;
  import cras_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [IDX_IN_W-1:0] run_start;
  logic [MARK_W-1:0]   high_water;
  logic [MARK_W-1:0]   peak_use;
  modport source (output valid, status, run_start, high_water, peak_use, input ready);
  modport sink   (input valid, status, run_start, high_water, peak_use, output ready);
endinterface

interface cras_cfg_if;
  import cras_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/cras_ram.sv -----
// Generic single write port RAM with one registered read port.
`default_nettype none
module cras_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/cras_word_eval.sv -----
// First-fit evaluation of one bitmap word inside the scan window.
`default_nettype none
module cras_word_eval #(
  parameter int RUN_W = 13
) (
  input  wire logic [cras_pkg::WORD_W-1:0] used,
  input  wire logic [cras_pkg::OFS_W-1:0]  lo,
  input  wire logic [cras_pkg::OFS_W:0]    hi,
  input  wire logic [RUN_W-1:0]            run,
  input  wire logic [cras_pkg::LEN_W-1:0]  count,
  output cras_pkg::cras_eval_t             ev
);
  import cras_pkg::*;

  localparam int SW = ((RUN_W > LEN_W) ? RUN_W : LEN_W) + 1;

  logic [WORD_W-1:0] win;
  logic [WORD_W-1:0] fmask;
  logic [WORD_W-1:0] umask;
  logic [WORD_W-1:0] emask;
  logic [OFS_W-1:0]  first_used;
  logic [OFS_W-1:0]  last_used;
  logic [OFS_W-1:0]  int_end;
  logic [OFS_W:0]    lead;
  logic [OFS_W:0]    int_tmp;
  logic              any_used;
  logic              short_run;
  logic              hit_lead;
  logic              hit_int;

  assign win      = span_mask(lo, hi);
  assign fmask    = ~used & win;
  assign umask    = used & win;
  assign any_used = |umask;

  always_comb begin
    first_used = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (umask[j]) begin
        first_used = OFS_W'(j);
      end
    end
  end

  always_comb begin
    last_used = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (umask[j]) begin
        last_used = OFS_W'(j);
      end
    end
  end

  assign lead     = any_used ? ({1'b0, first_used} - {1'b0, lo}) : (hi - {1'b0, lo});
  assign hit_lead = (SW'(run) + SW'(lead)) >= SW'(count);

  assign short_run = count <= LEN_W'(WORD_W);
  assign emask     = (any_used && short_run) ? run_end_mask(fmask, count[OFS_W:0]) : '0;
  assign hit_int   = |emask;

  always_comb begin
    int_end = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (emask[j]) begin
        int_end = OFS_W'(j);
      end
    end
  end

  assign int_tmp = {1'b0, int_end} + (OFS_W+1)'(1) - count[OFS_W:0];

  assign ev.hit       = hit_lead || hit_int;
  assign ev.hit_lead  = hit_lead;
  assign ev.int_start = int_tmp[OFS_W-1:0];
  assign ev.any_used  = any_used;
  assign ev.last_used = last_used;

endmodule
`default_nettype wire

// ----- sv/contiguous_run_slot_allocator_top.sv -----
// Top level of the contiguous run slot allocator: control, marks and bitmap memory.
//
//   channel  dir  beat payload                                  handshake
//   op       in   opcode, run_length, slot_index                valid/ready
//   res      out  status, run_start, high_water, peak_use       valid/ready
//   cfg      in   data (pool_limit)                             valid/ready, always ready
//
// The used bitmap sits in a RAM of 32-bit rows; one item is worked at a time.
// Free reads the slot's row and writes it back; clear and zero-length allocate skip the RAM.
// Allocate scans rows from the hint row to the high-water row until a fit is found, then marks
// each run row (read-modify-write, one row per cycle through the single write port).
// Reset is immediate: a row fill count makes rows past it read as free, no clear sweep.
// A stalled result holds in the output register while the next beat is accepted.
`default_nettype none
module contiguous_run_slot_allocator_top #(
  parameter int POOL_SIZE = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  cras_cfg_if.sink  cfg,
  cras_op_if.sink   op,
  cras_res_if.source res
);
  import cras_pkg::*;

  localparam int CNT_W  = $clog2(POOL_SIZE + 1);
  localparam int ROWS   = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FILL_W = $clog2(ROWS + 1);
  localparam int SUM_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_CHECK    = 7'b0001000,
    S_MARK     = 7'b0010000,
    S_FREE_WR  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op_q;
  logic [LEN_W-1:0]    len_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [LIMIT_W-1:0]  pool_limit;
  logic [CNT_W-1:0]    high_mark;
  logic [CNT_W-1:0]    free_hint;
  logic [CNT_W-1:0]    peak_mark;
  logic [FILL_W-1:0]   fill;
  logic [ROW_W-1:0]    scan_row;
  logic [ROW_W-1:0]    mark_row;
  logic [CNT_W-1:0]    start;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    need;
  logic [STAT_W-1:0]   st_q;
  logic [IDX_IN_W-1:0] rs_q;

  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [IDX_IN_W-1:0] out_start;
  logic [MARK_W-1:0]   out_high;
  logic [MARK_W-1:0]   out_peak;

  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  logic [ROW_W-1:0]    data_row;
  logic [WORD_W-1:0]   rd_word;

  logic [CNT_W-1:0]    hm_m1;
  logic [CNT_W-1:0]    need_m1;
  logic [ROW_W-1:0]    hint_row;
  logic [ROW_W-1:0]    last_row;
  logic [ROW_W-1:0]    start_row;
  logic [ROW_W-1:0]    end_row;
  logic [ROW_W-1:0]    idx_row;
  logic [CNT_W-1:0]    base;
  logic [OFS_W-1:0]    scan_lo;
  logic [OFS_W:0]      scan_hi;
  logic [OFS_W-1:0]    mark_lo;
  logic [OFS_W:0]      mark_hi;
  logic [OFS_W:0]      tail_len;
  logic [SUM_W-1:0]    need_sum;
  logic [SUM_W-1:0]    eff_limit;
  logic [FILL_W-1:0]   end_fill;
  logic                idx_ok;
  logic                out_free;
  cras_eval_t          ev;

  assign hm_m1     = high_mark - CNT_W'(1);
  assign need_m1   = need - CNT_W'(1);
  assign hint_row  = ROW_W'(free_hint >> OFS_W);
  assign last_row  = ROW_W'(hm_m1 >> OFS_W);
  assign start_row = ROW_W'(start >> OFS_W);
  assign end_row   = ROW_W'(need_m1 >> OFS_W);
  assign idx_row   = ROW_W'(idx_q >> OFS_W);
  assign base      = CNT_W'({scan_row, OFS_W'(0)});
  assign idx_ok    = SUM_W'(idx_q) < SUM_W'(POOL_SIZE);
  assign need_sum  = SUM_W'(start) + SUM_W'(len_q);
  assign eff_limit = (SUM_W'(pool_limit) > SUM_W'(POOL_SIZE)) ? SUM_W'(POOL_SIZE)
                                                               : SUM_W'(pool_limit);
  assign end_fill  = FILL_W'(end_row) + FILL_W'(1);

  assign scan_lo  = (scan_row == hint_row) ? free_hint[OFS_W-1:0] : '0;
  assign scan_hi  = (scan_row == last_row) ? ({1'b0, hm_m1[OFS_W-1:0]} + (OFS_W+1)'(1))
                                           : (OFS_W+1)'(WORD_W);
  assign mark_lo  = (mark_row == start_row) ? start[OFS_W-1:0] : '0;
  assign mark_hi  = (mark_row == end_row) ? ({1'b0, need_m1[OFS_W-1:0]} + (OFS_W+1)'(1))
                                          : (OFS_W+1)'(WORD_W);
  assign tail_len = scan_hi - (OFS_W+1)'(1) - {1'b0, ev.last_used};

  always_comb begin
    case (state)
      S_MARK:    data_row = mark_row;
      S_FREE_WR: data_row = idx_row;
      default:   data_row = scan_row;
    endcase
  end

  assign rd_word = (FILL_W'(data_row) < fill) ? ram_rdata : '0;

  always_comb begin
    case (state)
      S_DISPATCH: ram_raddr = (op_q == OP_FREE) ? idx_row : hint_row;
      S_SCAN:     ram_raddr = scan_row + ROW_W'(1);
      S_CHECK:    ram_raddr = start_row;
      S_MARK:     ram_raddr = mark_row + ROW_W'(1);
      default:    ram_raddr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = mark_row;
        ram_wdata = rd_word | span_mask(mark_lo, mark_hi);
      end
      S_FREE_WR: begin
        ram_we    = FILL_W'(idx_row) < fill;
        ram_waddr = idx_row;
        ram_wdata = rd_word & ~(WORD_W'(1) << idx_q[OFS_W-1:0]);
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
      end
    endcase
  end

  cras_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cras_word_eval #(
    .RUN_W (CNT_W)
  ) u_eval (
    .used  (rd_word),
    .lo    (scan_lo),
    .hi    (scan_hi),
    .run   (run),
    .count (len_q),
    .ev    (ev)
  );

  assign out_free = !out_valid || res.ready;

  assign op.ready       = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.run_start  = out_start;
  assign res.high_water = out_high;
  assign res.peak_use   = out_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pool_limit <= LIMIT_RESET;
      high_mark  <= '0;
      free_hint  <= '0;
      peak_mark  <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        pool_limit <= cfg.data;
      end
      if (out_valid && res.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (op.valid) begin
            op_q  <= op.opcode;
            len_q <= op.run_length;
            idx_q <= op.slot_index;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          st_q <= ((op_q == OP_ALLOC) && (len_q == '0)) ? ST_ZERO : ST_OK;
          rs_q <= '0;
          case (op_q)
            OP_ALLOC: begin
              start    <= free_hint;
              run      <= '0;
              scan_row <= hint_row;
              if (len_q == '0) begin
                state <= S_DONE;
              end else if (free_hint >= high_mark) begin
                state <= S_CHECK;
              end else begin
                state <= S_SCAN;
              end
            end
            OP_FREE: begin
              if (idx_ok) begin
                if (SUM_W'(idx_q) < SUM_W'(free_hint)) begin
                  free_hint <= CNT_W'(idx_q);
                end
                state <= S_FREE_WR;
              end else begin
                state <= S_DONE;
              end
            end
            OP_CLEAR: begin
              fill      <= '0;
              high_mark <= '0;
              free_hint <= '0;
              state     <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (ev.hit) begin
            if (!ev.hit_lead) begin
              start <= base + CNT_W'(ev.int_start);
            end
            state <= S_CHECK;
          end else begin
            if (ev.any_used) begin
              start <= base + CNT_W'(ev.last_used) + CNT_W'(1);
              run   <= CNT_W'(tail_len);
            end else begin
              run   <= run + CNT_W'(scan_hi - {1'b0, scan_lo});
            end
            if (scan_row == last_row) begin
              state <= S_CHECK;
            end else begin
              scan_row <= scan_row + ROW_W'(1);
            end
          end
        end
        S_CHECK: begin
          if (need_sum > eff_limit) begin
            st_q  <= ST_EXHAUST;
            state <= S_DONE;
          end else begin
            need     <= CNT_W'(need_sum);
            rs_q     <= IDX_IN_W'(start);
            mark_row <= start_row;
            if (SUM_W'(high_mark) <= need_sum) begin
              high_mark <= CNT_W'(need_sum);
              if (SUM_W'(peak_mark) < need_sum) begin
                peak_mark <= CNT_W'(need_sum);
              end
            end
            if (start == free_hint) begin
              free_hint <= CNT_W'(need_sum);
            end
            state <= S_MARK;
          end
        end
        S_MARK: begin
          if (mark_row == end_row) begin
            if (end_fill > fill) begin
              fill <= end_fill;
            end
            state <= S_DONE;
          end else begin
            mark_row <= mark_row + ROW_W'(1);
          end
        end
        S_FREE_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= st_q;
            out_start  <= rs_q;
            out_high   <= MARK_W'(high_mark);
            out_peak   <= MARK_W'(peak_mark);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
